// File: hdl/slef_pkg.sv
// Shared types and constants for the slew-limited EMA vector filter.
// Used by the controller, the datapath and the top level; depends on nothing.
package slef_pkg;

    // Fixed field widths of the ports
    localparam int CH_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 2'd1;

    // Axis codes for the per-axis filter pass
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Sum-of-squares pass: three raw terms, then three filtered terms,
    // one extra count to drain the squarer register
    localparam int                    SQ_TERMS      = 6;
    localparam int                    SQ_CNT_W      = 3;
    localparam logic [SQ_CNT_W-1:0]   SQ_CNT_LAST   = 3'(SQ_TERMS);
    localparam logic [SQ_CNT_W-1:0]   SQ_FILT_FIRST = 3'd3;

    // Reset values: 500 N/s at 100 Hz in 1/4096 N, and alpha of 0.3
    localparam longint MAX_STEP_DEFAULT     = 20480;
    localparam int     ALPHA_DEFAULT_TENTHS = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLEW,
        ST_MUL,
        ST_ADD,
        ST_SQUARE,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_FINISH
    } slef_state_t;

    typedef struct packed {
        logic                load;
        logic                slew_en;
        logic                mul_en;
        logic                add_en;
        logic [1:0]          axis;
        logic                sq_mul;
        logic [SQ_CNT_W-1:0] sq_sel;
        logic                root_init;
        logic                root_step;
        logic                finish;
    } slef_cmd_t;

endpackage

// File: hdl/slew_limited_ema_vector_filter_top.sv
// Slew-limited EMA filter for channel-tagged 3-axis force vectors; holds the
// alpha and max_step registers and joins slef_ctrl and slef_dp (slef_pkg).
// The first beat of a channel after reset passes through and seeds it; later
// beats are clamped per axis to max_step from the previous raw value and then
// smoothed with a Q1.ALPHA_FRAC_BITS alpha (values above 1.0 act as 1.0).
// Channels at or above CHANNELS pass through untouched. One item is in work
// at a time: the next item is accepted only after the finish step, which
// waits for a free result register; the time in work is set mostly by the
// bit-serial square roots that produce both magnitudes, one bit a cycle.
// A finished result waits in the output register, so the next item can enter
// while it is still stalled. The channel store needs no clearing pass.
module slew_limited_ema_vector_filter_top
    import slef_pkg::*;
#(
    parameter int CHANNELS        = 7,
    parameter int SAMPLE_BITS     = 24,
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [CH_W-1:0]               channel,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    input  logic signed [SAMPLE_BITS-1:0] y_in,
    input  logic signed [SAMPLE_BITS-1:0] z_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [CH_W-1:0]               channel_out,
    output logic signed [SAMPLE_BITS-1:0] x_out,
    output logic signed [SAMPLE_BITS-1:0] y_out,
    output logic signed [SAMPLE_BITS-1:0] z_out,
    output logic [SAMPLE_BITS-1:0]        raw_magnitude,
    output logic [SAMPLE_BITS-1:0]        filtered_magnitude
);

    localparam int     SB        = SAMPLE_BITS;
    localparam int     AF        = ALPHA_FRAC_BITS;
    localparam longint ALPHA_RST =
        ((longint'(1) << AF) * ALPHA_DEFAULT_TENTHS + 5) / 10;
    localparam longint STEP_LIM  = (longint'(1) << (SB - 1)) - 1;
    localparam longint STEP_RST  =
        (STEP_LIM < MAX_STEP_DEFAULT) ? STEP_LIM : MAX_STEP_DEFAULT;
    localparam logic [AF:0] ALPHA_ONE = {1'b1, {AF{1'b0}}};

    logic [AF:0]   alpha_reg;
    logic [SB-2:0] max_step_reg;
    logic [AF:0]   alpha_eff;
    slef_cmd_t     cmd;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg    <= (AF+1)'(ALPHA_RST);
            max_step_reg <= (SB-1)'(STEP_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ALPHA:    alpha_reg    <= cfg_data[AF:0];
                REG_MAX_STEP: max_step_reg <= cfg_data[SB-2:0];
                default:      alpha_reg    <= alpha_reg;
            endcase
        end
    end

    // Cap alpha at one
    assign alpha_eff = alpha_reg[AF] ? ALPHA_ONE : alpha_reg;

    slef_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    slef_dp #(
        .CHANNELS        (CHANNELS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .alpha              (alpha_eff),
        .max_step           (max_step_reg),
        .channel            (channel),
        .x_in               (x_in),
        .y_in               (y_in),
        .z_in               (z_in),
        .channel_out        (channel_out),
        .x_out              (x_out),
        .y_out              (y_out),
        .z_out              (z_out),
        .raw_magnitude      (raw_magnitude),
        .filtered_magnitude (filtered_magnitude)
    );

    // One item in work at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second beat accepted while an item is in work");

    // A result appears only from the finish step
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.finish))
        else $error("result presented without a finish step");

    // Never overwrite a result that is still stalled
    a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid || !out_stall))
        else $error("result register overwritten while stalled");

    // Datapath steps are exclusive
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.slew_en, cmd.mul_en, cmd.add_en, cmd.sq_mul,
                  cmd.root_init, cmd.root_step, cmd.finish}))
        else $error("overlapping datapath commands");

endmodule

// File: hdl/slef_isqrt.sv
// Bit-serial floor square root, one result bit per step.
// Standalone; sequenced by the datapath's init and step strobes.
module slef_isqrt #(
    parameter int ROOT_W = 25
) (
    input  logic                  clk,
    input  logic                  init,
    input  logic                  step,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic [ROOT_W-1:0]     root
);

    localparam int REM_W = ROOT_W + 2;

    logic [2*ROOT_W-1:0] rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;

    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic                fits;

    // Bring down the next two radicand bits and try the next root bit
    always_comb
    begin
        rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[2*ROOT_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        fits   = (rem_sh >= trial);
    end

    // Load, then advance one bit per step
    always_ff @(posedge clk)
    begin
        if (init)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (step)
        begin
            rad_reg  <= {rad_reg[2*ROOT_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign root = root_reg;

endmodule

// File: hdl/slef_dp.sv
// Datapath: channel state memory, slew limit, EMA, sums of squares and
// output register. Depends on slef_pkg and slef_isqrt.
module slef_dp
    import slef_pkg::*;
#(
    parameter int CHANNELS        = 7,
    parameter int SAMPLE_BITS     = 24,
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slef_cmd_t                     cmd,
    input  logic [ALPHA_FRAC_BITS:0]      alpha,
    input  logic [SAMPLE_BITS-2:0]        max_step,
    input  logic [CH_W-1:0]               channel,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    input  logic signed [SAMPLE_BITS-1:0] y_in,
    input  logic signed [SAMPLE_BITS-1:0] z_in,
    output logic [CH_W-1:0]               channel_out,
    output logic signed [SAMPLE_BITS-1:0] x_out,
    output logic signed [SAMPLE_BITS-1:0] y_out,
    output logic signed [SAMPLE_BITS-1:0] z_out,
    output logic [SAMPLE_BITS-1:0]        raw_magnitude,
    output logic [SAMPLE_BITS-1:0]        filtered_magnitude
);

    localparam int SB      = SAMPLE_BITS;
    localparam int AF      = ALPHA_FRAC_BITS;
    localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENTRY_W = 6 * SB;
    localparam int PROD_W  = SB + AF + 3;
    localparam int SQ_W    = 2 * SB;
    localparam int SUM_W   = 2 * SB + 2;
    localparam int ROOT_W  = SB + 1;

    localparam logic signed [SB-1:0]     SMAX   = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0]     SMIN   = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] SMAX_W = PROD_W'(SMAX);
    localparam logic signed [PROD_W-1:0] SMIN_W = PROD_W'(SMIN);
    localparam logic signed [PROD_W-1:0] HALF   =
        {{(PROD_W-AF){1'b0}}, 1'b1, {(AF-1){1'b0}}};

    // Per-channel store: low three words previous raw, high three smoothed
    logic [ENTRY_W-1:0]      mem [CHANNELS];
    logic [ENTRY_W-1:0]      rd_reg;
    logic [CHANNELS-1:0]     seen_reg;

    logic [CH_W-1:0]         ch_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    inrange_reg;
    logic                    bypass_reg;
    logic signed [SB-1:0]    raw_reg  [3];
    logic signed [SB-1:0]    filt_reg [3];
    logic signed [SB-1:0]    slew_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic                    sq_valid_d_reg;
    logic                    sq_raw_d_reg;
    logic [SUM_W-1:0]        sum_raw_reg;
    logic [SUM_W-1:0]        sum_filt_reg;

    logic [CH_W-1:0]         channel_out_reg;
    logic signed [SB-1:0]    x_out_reg;
    logic signed [SB-1:0]    y_out_reg;
    logic signed [SB-1:0]    z_out_reg;
    logic [SB-1:0]           raw_mag_reg;
    logic [SB-1:0]           filt_mag_reg;

    logic                    in_range;
    logic [IDX_W-1:0]        rd_idx;
    logic signed [SB-1:0]    cur_raw;
    logic signed [SB-1:0]    cur_prev;
    logic signed [SB-1:0]    cur_st;
    logic signed [SB:0]      diff;
    logic signed [SB:0]      step_lim;
    logic signed [SB:0]      lim_hi;
    logic signed [SB:0]      lim_lo;
    logic signed [SB:0]      slew_wide;
    logic signed [SB-1:0]    slew_val;
    logic signed [SB:0]      ema_diff;
    logic signed [AF+1:0]    alpha_s;
    logic signed [PROD_W-1:0] ema_sum;
    logic signed [PROD_W-1:0] ema_shift;
    logic signed [SB-1:0]    ema_val;
    logic signed [SB-1:0]    sq_src;
    logic [SB-1:0]           sq_abs;
    logic [ROOT_W-1:0]       raw_root;
    logic [ROOT_W-1:0]       filt_root;

    // Channel decode; out-of-range channels read entry zero and bypass
    always_comb
    begin
        in_range = (int'(channel) < CHANNELS);
        rd_idx   = in_range ? IDX_W'(channel) : '0;
    end

    // Select the axis under work
    always_comb
    begin
        case (cmd.axis)
            AXIS_X:
            begin
                cur_raw  = raw_reg[0];
                cur_prev = rd_reg[0*SB +: SB];
                cur_st   = rd_reg[3*SB +: SB];
            end
            AXIS_Y:
            begin
                cur_raw  = raw_reg[1];
                cur_prev = rd_reg[1*SB +: SB];
                cur_st   = rd_reg[4*SB +: SB];
            end
            default:
            begin
                cur_raw  = raw_reg[2];
                cur_prev = rd_reg[2*SB +: SB];
                cur_st   = rd_reg[5*SB +: SB];
            end
        endcase
    end

    // Clamp the step against the previous raw value, then saturate
    always_comb
    begin
        diff     = {cur_raw[SB-1], cur_raw} - {cur_prev[SB-1], cur_prev};
        step_lim = {2'b00, max_step};
        lim_hi   = {cur_prev[SB-1], cur_prev} + step_lim;
        lim_lo   = {cur_prev[SB-1], cur_prev} - step_lim;
        if (diff > step_lim)
            slew_wide = lim_hi;
        else if (diff < -step_lim)
            slew_wide = lim_lo;
        else
            slew_wide = {cur_raw[SB-1], cur_raw};
        if (slew_wide[SB] != slew_wide[SB-1])
            slew_val = slew_wide[SB] ? SMIN : SMAX;
        else
            slew_val = slew_wide[SB-1:0];
    end

    // EMA as smooth + alpha * (slewed - smooth), rounded half up
    always_comb
    begin
        ema_diff  = {slew_reg[SB-1], slew_reg} - {cur_st[SB-1], cur_st};
        alpha_s   = {1'b0, alpha};
        ema_sum   = prod_reg + (PROD_W'(cur_st) <<< AF) + HALF;
        ema_shift = ema_sum >>> AF;
        if (ema_shift > SMAX_W)
            ema_val = SMAX;
        else if (ema_shift < SMIN_W)
            ema_val = SMIN;
        else
            ema_val = ema_shift[SB-1:0];
    end

    // Pick the term to square: raw axes first, then filtered
    always_comb
    begin
        case (cmd.sq_sel)
            3'd0:    sq_src = raw_reg[0];
            3'd1:    sq_src = raw_reg[1];
            3'd2:    sq_src = raw_reg[2];
            3'd3:    sq_src = filt_reg[0];
            3'd4:    sq_src = filt_reg[1];
            default: sq_src = filt_reg[2];
        endcase
        sq_abs = sq_src[SB-1] ? $unsigned(-sq_src) : $unsigned(sq_src);
    end

    // Capture the beat and read the channel's stored entry
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg      <= channel;
            raw_reg[0]  <= x_in;
            raw_reg[1]  <= y_in;
            raw_reg[2]  <= z_in;
            idx_reg     <= rd_idx;
            inrange_reg <= in_range;
            bypass_reg  <= !in_range || !seen_reg[rd_idx];
            rd_reg      <= mem[rd_idx];
        end
        if (cmd.finish && inrange_reg)
        begin
            mem[idx_reg] <= {filt_reg[2], filt_reg[1], filt_reg[0],
                             raw_reg[2], raw_reg[1], raw_reg[0]};
        end
    end

    // Mark channels seeded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else if (cmd.finish && inrange_reg)
            seen_reg[idx_reg] <= 1'b1;
    end

    // Per-axis filter pipeline: slew, multiply, add and store
    always_ff @(posedge clk)
    begin
        if (cmd.slew_en)
            slew_reg <= slew_val;
        if (cmd.mul_en)
            prod_reg <= ema_diff * alpha_s;
        if (cmd.add_en)
        begin
            case (cmd.axis)
                AXIS_X:  filt_reg[0] <= bypass_reg ? cur_raw : ema_val;
                AXIS_Y:  filt_reg[1] <= bypass_reg ? cur_raw : ema_val;
                default: filt_reg[2] <= bypass_reg ? cur_raw : ema_val;
            endcase
        end
    end

    // Track which squarer result is pending
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_d_reg <= 1'b0;
            sq_raw_d_reg   <= 1'b0;
        end
        else
        begin
            sq_valid_d_reg <= cmd.sq_mul;
            sq_raw_d_reg   <= (cmd.sq_sel < SQ_FILT_FIRST);
        end
    end

    // Square, then accumulate the registered square in the next cycle
    always_ff @(posedge clk)
    begin
        if (cmd.sq_mul)
            sq_reg <= sq_abs * sq_abs;
        if (cmd.load)
        begin
            sum_raw_reg  <= '0;
            sum_filt_reg <= '0;
        end
        else if (sq_valid_d_reg)
        begin
            if (sq_raw_d_reg)
                sum_raw_reg <= sum_raw_reg + SUM_W'(sq_reg);
            else
                sum_filt_reg <= sum_filt_reg + SUM_W'(sq_reg);
        end
    end

    slef_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_raw_root (
        .clk      (clk),
        .init     (cmd.root_init),
        .step     (cmd.root_step),
        .radicand (sum_raw_reg),
        .root     (raw_root)
    );

    slef_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_filt_root (
        .clk      (clk),
        .init     (cmd.root_init),
        .step     (cmd.root_step),
        .radicand (sum_filt_reg),
        .root     (filt_root)
    );

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            channel_out_reg <= ch_reg;
            x_out_reg       <= filt_reg[0];
            y_out_reg       <= filt_reg[1];
            z_out_reg       <= filt_reg[2];
            raw_mag_reg     <= raw_root[SB-1:0];
            filt_mag_reg    <= filt_root[SB-1:0];
        end
    end

    assign channel_out        = channel_out_reg;
    assign x_out              = x_out_reg;
    assign y_out              = y_out_reg;
    assign z_out              = z_out_reg;
    assign raw_magnitude      = raw_mag_reg;
    assign filtered_magnitude = filt_mag_reg;

endmodule

// File: hdl/slef_ctrl.sv
// Controller: sequences one item through the datapath and owns the
// handshake state. Depends on slef_pkg.
module slef_ctrl
    import slef_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output slef_cmd_t cmd
);

    localparam int                ROOT_STEPS = SAMPLE_BITS + 1;
    localparam int                STEP_W     = $clog2(ROOT_STEPS + 1);
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(ROOT_STEPS - 1);

    slef_state_t          state_reg;
    slef_state_t          state_next;
    logic [1:0]           axis_reg;
    logic [1:0]           axis_next;
    logic [SQ_CNT_W-1:0]  sq_reg;
    logic [SQ_CNT_W-1:0]  sq_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    // Next state and counters
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        sq_next    = sq_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SLEW;
                    axis_next  = AXIS_X;
                end
            end
            ST_SLEW:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_ADD;
            ST_ADD:
            begin
                if (axis_reg == AXIS_Z)
                begin
                    state_next = ST_SQUARE;
                    sq_next    = '0;
                end
                else
                begin
                    state_next = ST_SLEW;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            ST_SQUARE:
            begin
                if (sq_reg == SQ_CNT_LAST)
                    state_next = ST_ROOT_INIT;
                else
                    sq_next = sq_reg + 1'b1;
            end
            ST_ROOT_INIT:
            begin
                state_next = ST_ROOT;
                step_next  = '0;
            end
            ST_ROOT:
            begin
                if (step_reg == STEP_LAST)
                    state_next = ST_FINISH;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd           = '0;
        cmd.axis      = axis_reg;
        cmd.sq_sel    = sq_reg;
        case (state_reg)
            ST_IDLE:      cmd.load      = in_valid;
            ST_SLEW:      cmd.slew_en   = 1'b1;
            ST_MUL:       cmd.mul_en    = 1'b1;
            ST_ADD:       cmd.add_en    = 1'b1;
            ST_SQUARE:    cmd.sq_mul    = (sq_reg != SQ_CNT_LAST);
            ST_ROOT_INIT: cmd.root_init = 1'b1;
            ST_ROOT:      cmd.root_step = 1'b1;
            ST_FINISH:    cmd.finish    = slot_free;
            default:      cmd.load      = 1'b0;
        endcase
    end

    // Hold a result until the beat is taken
    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_X;
            sq_reg        <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            sq_reg        <= sq_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: dv/slef_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the slew-limited EMA vector filter: watches the register, sample
// and result channels, keeps its own per-channel filter state and checks results.
// Depends on slef_pkg for port widths, register indexes and reset values.
module slef_checker
    import slef_pkg::*;
#(
    parameter int CHANNELS        = 7,
    parameter int SAMPLE_BITS     = 24,
    parameter int ALPHA_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [CH_W-1:0]               channel,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    input  logic signed [SAMPLE_BITS-1:0] y_in,
    input  logic signed [SAMPLE_BITS-1:0] z_in,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [CH_W-1:0]               channel_out,
    input  logic signed [SAMPLE_BITS-1:0] x_out,
    input  logic signed [SAMPLE_BITS-1:0] y_out,
    input  logic signed [SAMPLE_BITS-1:0] z_out,
    input  logic [SAMPLE_BITS-1:0]        raw_magnitude,
    input  logic [SAMPLE_BITS-1:0]        filtered_magnitude,
    output int                            mismatches,
    output int                            backlog,
    output int                            checked
);

    localparam longint ONE         = longint'(1) << ALPHA_FRAC_BITS;
    localparam longint S_MAX       = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint S_MIN       = -(longint'(1) << (SAMPLE_BITS - 1));
    localparam longint ALPHA_MASK  = (longint'(1) << (ALPHA_FRAC_BITS + 1)) - 1;
    localparam longint STEP_MASK   = S_MAX;
    localparam longint ALPHA_RESET = 19661;
    localparam int     REPORT_MAX  = 10;

    typedef struct packed {
        logic [CH_W-1:0]        channel;
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
        logic [SAMPLE_BITS-1:0] z;
        logic [SAMPLE_BITS-1:0] raw_mag;
        logic [SAMPLE_BITS-1:0] filt_mag;
    } filt_result_t;

    // Register copies and per-channel filter state
    longint       alpha_q;
    longint       step_q;
    bit           seen [CHANNELS];
    longint       last_raw [CHANNELS][3];
    longint       smooth [CHANNELS][3];
    filt_result_t pending_vectors [$];

    function automatic longint clamp_sample(input longint v);
        if (v > S_MAX)
            return S_MAX;
        if (v < S_MIN)
            return S_MIN;
        return v;
    endfunction

    // Limit the change from the previous raw value to max_step
    function automatic longint slew_step(input longint raw, input longint prev);
        longint d;
        d = raw - prev;
        if (d > step_q)
            return clamp_sample(prev + step_q);
        if (d < -step_q)
            return clamp_sample(prev - step_q);
        return raw;
    endfunction

    // EMA with round half up; alpha above one acts as one
    function automatic longint ema_step(input longint s, input longint st);
        longint a;
        a = (alpha_q > ONE) ? ONE : alpha_q;
        return clamp_sample((a * s + (ONE - a) * st + ONE / 2) >>> ALPHA_FRAC_BITS);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic longint unsigned magnitude(input longint x, y, z);
        return floor_sqrt(longint'(x * x + y * y + z * z));
    endfunction

    // Filter one sample beat and advance the channel state
    function automatic filt_result_t filter_sample(input logic [CH_W-1:0] ch,
        input logic signed [SAMPLE_BITS-1:0] xi, yi, zi);
        longint       raw [3];
        longint       filt [3];
        filt_result_t r;
        raw[0] = xi;
        raw[1] = yi;
        raw[2] = zi;
        filt   = raw;
        if (int'(ch) < CHANNELS)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (seen[ch])
                    filt[a] = ema_step(slew_step(raw[a], last_raw[ch][a]), smooth[ch][a]);
                last_raw[ch][a] = raw[a];
                smooth[ch][a]   = filt[a];
            end
            seen[ch] = 1'b1;
        end
        r.channel  = ch;
        r.x        = SAMPLE_BITS'(filt[0]);
        r.y        = SAMPLE_BITS'(filt[1]);
        r.z        = SAMPLE_BITS'(filt[2]);
        r.raw_mag  = SAMPLE_BITS'(magnitude(raw[0], raw[1], raw[2]));
        r.filt_mag = SAMPLE_BITS'(magnitude(filt[0], filt[1], filt[2]));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filt_result_t want;
        filt_result_t got;
        if (!rst_n)
        begin
            alpha_q = ALPHA_RESET;
            step_q  = MAX_STEP_DEFAULT;
            foreach (seen[c])
                seen[c] = 1'b0;
            pending_vectors.delete();
            mismatches = 0;
            backlog    = 0;
            checked    = 0;
        end
        else
        begin
            // Take register writes; unknown indexes change nothing
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ALPHA)
                    alpha_q = longint'(cfg_data) & ALPHA_MASK;
                else if (cfg_index == REG_MAX_STEP)
                    step_q = longint'(cfg_data) & STEP_MASK;
            end

            // Compare a result beat with the oldest prediction
            if (out_valid && !out_stall)
            begin
                got.channel  = channel_out;
                got.x        = x_out;
                got.y        = y_out;
                got.z        = z_out;
                got.raw_mag  = raw_magnitude;
                got.filt_mag = filtered_magnitude;
                if (pending_vectors.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result beat on channel %0d with no sample pending",
                                 $realtime, channel_out);
                end
                else
                begin
                    want = pending_vectors.pop_front();
                    checked++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $write("%0t: mismatch (expected/actual) ch %0d/%0d x %0d/%0d ",
                                   $realtime, want.channel, got.channel,
                                   $signed(want.x), $signed(got.x));
                            $display("y %0d/%0d z %0d/%0d raw_mag %0d/%0d filt_mag %0d/%0d",
                                     $signed(want.y), $signed(got.y),
                                     $signed(want.z), $signed(got.z),
                                     want.raw_mag, got.raw_mag,
                                     want.filt_mag, got.filt_mag);
                        end
                    end
                end
            end

            // Predict the result of each accepted sample beat
            if (in_valid && !in_stall)
                pending_vectors.insert(pending_vectors.size(),
                                       filter_sample(channel, x_in, y_in, z_in));
            backlog = pending_vectors.size();
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the slew-limited EMA vector filter: clock, reset, register
// writes, sample stimulus with sender gaps and receiver stalls, watchdog, verdict.
// Depends on slef_pkg, slew_limited_ema_vector_filter_top and slef_checker.
module testbench;
    import slef_pkg::*;

    localparam int     CHANNELS    = 7;
    localparam int     SB          = 24;
    localparam int     FRAC        = 16;
    localparam longint S_MAX       = (longint'(1) << (SB - 1)) - 1;
    localparam longint S_MIN       = -(longint'(1) << (SB - 1));
    localparam longint STEP_MASK   = S_MAX;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // decodes to no register
    localparam int     HOLD_CYCLES    = 400;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     DRAIN_CYCLES   = 100;
    localparam int     SEND_IDLE [4]  = '{0, 56, 0, 33};
    localparam int     RECV_STALL [4] = '{0, 0, 56, 33};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [CH_W-1:0]      channel;
    logic signed [SB-1:0] x_in;
    logic signed [SB-1:0] y_in;
    logic signed [SB-1:0] z_in;
    logic                 out_valid;
    logic                 out_stall;
    logic [CH_W-1:0]      channel_out;
    logic signed [SB-1:0] x_out;
    logic signed [SB-1:0] y_out;
    logic signed [SB-1:0] z_out;
    logic [SB-1:0]        raw_magnitude;
    logic [SB-1:0]        filtered_magnitude;

    int     mismatches;
    int     backlog;
    int     checked;
    int     in_idle_pct;
    int     out_stall_pct;
    int     hold_requests;
    int     holds_done;
    int     hold_count;
    int     quiet_cycles;
    int     samples_sent;
    int     settings_used;
    longint cur_step;
    longint last_sent [8][3];  // steers random samples near each channel's last one

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    slew_limited_ema_vector_filter_top #(
        .CHANNELS        (CHANNELS),
        .SAMPLE_BITS     (SB),
        .ALPHA_FRAC_BITS (FRAC)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .channel            (channel),
        .x_in               (x_in),
        .y_in               (y_in),
        .z_in               (z_in),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .channel_out        (channel_out),
        .x_out              (x_out),
        .y_out              (y_out),
        .z_out              (z_out),
        .raw_magnitude      (raw_magnitude),
        .filtered_magnitude (filtered_magnitude)
    );

    slef_checker #(
        .CHANNELS        (CHANNELS),
        .SAMPLE_BITS     (SB),
        .ALPHA_FRAC_BITS (FRAC)
    ) filter_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .channel            (channel),
        .x_in               (x_in),
        .y_in               (y_in),
        .z_in               (z_in),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .channel_out        (channel_out),
        .x_out              (x_out),
        .y_out              (y_out),
        .z_out              (z_out),
        .raw_magnitude      (raw_magnitude),
        .filtered_magnitude (filtered_magnitude),
        .mismatches         (mismatches),
        .backlog            (backlog),
        .checked            (checked)
    );

    // Receiver: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        out_stall  = 1'b0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Watchdog: end the run after too many cycles with no beat on any channel
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Offer one sample beat after a random gap and hold it until accepted
    task automatic send_sample(input int ch, input longint x, y, z);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        channel  <= CH_W'(ch);
        x_in     <= SB'(x);
        y_in     <= SB'(y);
        z_in     <= SB'(z);
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        last_sent[ch][0] = x;
        last_sent[ch][1] = y;
        last_sent[ch][2] = z;
        samples_sent++;
    endtask

    // Mostly a move around the last value of the axis, within and past max_step
    function automatic longint pick_axis(input longint base);
        longint span;
        longint v;
        span = 2 * cur_step + 3;
        case ($urandom_range(9))
            0:       v = longint'($urandom_range(0, 32'(2 * S_MAX + 1))) + S_MIN;
            1:       v = $urandom_range(1) ? S_MAX : S_MIN;
            default: v = base + longint'($urandom_range(0, 32'(2 * span))) - span;
        endcase
        if (v > S_MAX)
            v = S_MAX;
        if (v < S_MIN)
            v = S_MIN;
        return v;
    endfunction

    task automatic send_random();
        int ch;
        ch = ($urandom_range(15) == 0) ? 7 : $urandom_range(CHANNELS - 1);
        send_sample(ch, pick_axis(last_sent[ch][0]), pick_axis(last_sent[ch][1]),
                    pick_axis(last_sent[ch][2]));
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (backlog != 0);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] alpha_word, step_word);
        write_reg(REG_ALPHA, alpha_word);
        write_reg(REG_MAX_STEP, step_word);
        cfg_valid <= 1'b0;
        cur_step  = longint'(step_word) & STEP_MASK;
        settings_used++;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] alpha_word, step_word,
                             input int idle, stall, count);
        settle();
        configure(alpha_word, step_word);
        in_idle_pct   = idle;
        out_stall_pct = stall;
        repeat (count)
            send_random();
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] alpha_word;
        logic [CFG_DATA_W-1:0] step_word;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_ALPHA;
        cfg_data      = '0;
        in_valid      = 1'b0;
        channel       = '0;
        x_in          = '0;
        y_in          = '0;
        z_in          = '0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_requests = 0;
        samples_sent  = 0;
        settings_used = 1;
        cur_step      = MAX_STEP_DEFAULT;
        foreach (last_sent[c, a])
            last_sent[c][a] = 0;

        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed samples at the reset settings: seeding, clamps, full scale
        send_sample(0, 0, 0, 0);
        send_sample(0, S_MAX, S_MAX, S_MAX);
        send_sample(0, S_MIN, S_MIN, S_MIN);
        send_sample(1, S_MIN, S_MIN, S_MIN);
        send_sample(1, S_MAX, S_MIN, 0);
        send_sample(2, 1000, -1000, 5);
        // x and y land exactly on max_step, z one past it
        send_sample(2, 21480, -21480, 20486);
        send_sample(2, 21480, -21480, 20486);
        send_sample(3, -1, -1, -1);
        send_sample(3, -2, 0, -3);
        send_sample(4, S_MAX, S_MAX, S_MAX);
        send_sample(4, S_MAX - 1, S_MAX, S_MAX - 20481);
        send_sample(5, 5592405, -2796202, 986895);
        send_sample(6, 123456, -654321, 2000000);
        send_sample(6, 123460, -654330, 2000100);
        // channel tag past the last channel passes through
        send_sample(7, S_MAX, S_MIN, -1);
        send_sample(7, 0, 0, 0);
        send_sample(0, 1, -1, 0);

        // Write to an index that decodes to no register
        settle();
        write_reg(REG_SPARE, $urandom);

        // Extreme settings: alpha one, zero, above one with junk in the upper bits, one LSB
        run_phase(32'd65536, 32'd0, SEND_IDLE[0], RECV_STALL[0], 80);
        run_phase(32'd0, 32'd8388607, SEND_IDLE[1], RECV_STALL[1], 80);
        run_phase(32'hFFFF_FFFF, 32'd1, SEND_IDLE[2], RECV_STALL[2], 80);
        run_phase(32'd1, 32'hFF80_5000, SEND_IDLE[3], RECV_STALL[3], 80);

        // Hold the receiver off while samples keep coming, so the input backs up
        settle();
        configure(32'd32768, 32'd4096);
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_requests++;
        repeat (30)
            send_random();

        // Random settings, cycling through the idle patterns
        for (int p = 0; p < 6; p++)
        begin
            alpha_word = ($urandom_range(3) == 0) ? $urandom_range(131071, 65537)
                                                  : $urandom_range(65536);
            if ($urandom_range(1))
                alpha_word[CFG_DATA_W-1:FRAC+1] = (CFG_DATA_W-FRAC-1)'($urandom);
            case ($urandom_range(2))
                0:       step_word = $urandom_range(64);
                1:       step_word = $urandom_range(100000);
                default: step_word = $urandom_range(32'(S_MAX));
            endcase
            if ($urandom_range(1))
                step_word[CFG_DATA_W-1:SB-1] = (CFG_DATA_W-SB+1)'($urandom);
            run_phase(alpha_word, step_word, SEND_IDLE[p % 4], RECV_STALL[p % 4], 75);
        end

        // Drain and let any stray result show up
        settle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Run covered %0d samples on channel tags 0-7 over %0d register settings,",
                 samples_sent, settings_used);
        $display("with %0d results checked under sender gaps, stalls and a %0d-cycle hold-off",
                 checked, HOLD_CYCLES);
        if (mismatches == 0 && backlog == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/slef_pkg.sv
hdl/slef_isqrt.sv
hdl/slef_dp.sv
hdl/slef_ctrl.sv
hdl/slew_limited_ema_vector_filter_top.sv
dv/slef_checker.sv
dv/testbench.sv
